// File: design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

// Check that a condition implies another one on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/imu_dec_pkg.sv
package imu_dec_pkg;

	localparam int OVERSAMPLE_DEF = 10;
	localparam int NUM_CH         = 6;
	localparam int SAMPLE_W       = 12;
	localparam int OFFSET_W       = 13;
	localparam int WSUM_W         = 15;
	localparam int SCALE_W        = 16;
	localparam int TAP_IDX_W      = 6;
	localparam int WEIGHT_W       = 16;
	localparam int SUM_W          = 40;
	localparam int PROD_W         = 56;
	localparam int RES_W          = 32;
	localparam int MUL_A_W        = 21;
	localparam int MUL_B_W        = 17;
	localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
	localparam int HALF_W         = SUM_W / 2;
	localparam int CH_W           = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	// input tdata layout
	localparam int IN_SAMPLES_W   = NUM_CH * SAMPLE_W;
	localparam int IN_TAP_IDX_LO  = IN_SAMPLES_W;
	localparam int IN_WEIGHT_LO   = IN_TAP_IDX_LO + TAP_IDX_W;
	localparam int IN_DATA_W      = 96;
	localparam int OUT_DATA_W     = NUM_CH * RES_W;

	localparam logic signed [OFFSET_W-1:0] ACCEL_OFFSET_RST = -13'sd2048;
	localparam logic signed [OFFSET_W-1:0] GYRO_OFFSET_RST  = -13'sd1675;
	localparam logic [WSUM_W-1:0]          WEIGHT_SUM_RST   = 15'd10;
	localparam logic [SCALE_W-1:0]         ACCEL_SCALE_RST  = 16'd785;
	localparam logic [SCALE_W-1:0]         GYRO_SCALE_RST   = 16'd461;

	localparam logic CMD_FRAME     = 1'b0;
	localparam logic CMD_TAP_WRITE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEL_OFFSET,
		CFG_GYRO_OFFSET,
		CFG_WEIGHT_SUM,
		CFG_ACCEL_SCALE,
		CFG_GYRO_SCALE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MAC,
		ST_FIN_LO,
		ST_FIN_HI,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} imu_state_t;

	// Request from the sequencer to the divider.
	typedef struct packed {
		logic                  start;
		logic [PROD_W-1:0]     dividend;
		logic [WSUM_W-1:0]     divisor;
	} div_req_t;

	// Output slot to accumulator channel: accel X, Y, Z then gyro X, Y, Z.
	function automatic logic [CH_W-1:0] out_chan(input logic [CH_W-1:0] slot);
		logic [CH_W-1:0] ch;
		case (slot)
			3'd0:    ch = 3'd0;
			3'd1:    ch = 3'd2;
			3'd2:    ch = 3'd4;
			3'd3:    ch = 3'd1;
			3'd4:    ch = 3'd3;
			3'd5:    ch = 3'd5;
			default: ch = 3'd0;
		endcase
		return ch;
	endfunction

endpackage

// File: design/imu_dec_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. Unsigned dividend, nonzero divisor.
module imu_dec_div
	import imu_dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              busy,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] dq_q;
	logic [WSUM_W-1:0] rem_q;
	logic [WSUM_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [WSUM_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dq_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(PROD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			// shift next dividend bit into the remainder, subtract if it fits
			rem_q <= fits ? WSUM_W'(trial - {1'b0, dvs_q}) : trial[WSUM_W-1:0];
			dq_q  <= {dq_q[PROD_W-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = dq_q;

	`ASSERT_NEXT(a_div_done_after_last, clk, arst_n, cnt_q == CNT_W'(1) && !req.start, done_q)
	`ASSERT_ALWAYS(a_div_done_not_busy, clk, arst_n, !(done_q && cnt_q != '0))
	`ASSERT_ALWAYS(a_div_rem_below_divisor, clk, arst_n, !busy || rem_q < dvs_q || dvs_q == '0)

endmodule

// File: design/oversampled_imu_decimator.sv
// Oversampled IMU decimator. Each input transaction is either a sample frame
// (tuser = 0: six 12-bit ADC counts, accel X/gyro X/accel Y/gyro Y/accel Z/
// gyro Z) or a tap weight write (tuser = 1: tap_index and signed tap_weight;
// indexes at or above OVERSAMPLE are dropped). Per frame, each channel's count
// plus its offset is multiplied by the weight of the frame's window position
// and accumulated. After OVERSAMPLE frames one output transaction carries six
// 32-bit values: sum times unsigned 16-bit integer scale, divided by weight_sum
// (zero taken as one), truncated toward zero and saturated. A frame is accepted,
// reads the tap memory, then makes six passes through the shared 21x17 multiplier.
// The frame that closes a window then, for each output value, forms two partial
// products, starts the divider and waits for its 56-step bit-serial divide; the
// results are then handed over to the output register, which may further wait
// while the previous output transaction has not been taken. Configuration
// writes are accepted every cycle and must only happen while the block is idle.
`include "assert_macros.svh"

module oversampled_imu_decimator
	import imu_dec_pkg::*;
#(
	parameter int OVERSAMPLE = OVERSAMPLE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample frames and tap weight writes
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sample_ch0 [11:0], sample_ch1 [23:12], sample_ch2 [35:24], sample_ch3 [47:36],
	// sample_ch4 [59:48], sample_ch5 [71:60], tap_index [77:72], tap_weight [93:78]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command [0]
	input  logic                  s_tuser,
	// decimated results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// accel_x [31:0], accel_y [63:32], accel_z [95:64],
	// rate_x [127:96], rate_y [159:128], rate_z [191:160]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

	// configuration registers
	logic signed [OFFSET_W-1:0] accel_off_q, gyro_off_q;
	logic [WSUM_W-1:0]          wsum_q;
	logic [SCALE_W-1:0]         accel_scale_q, gyro_scale_q;

	// tap memory with per-entry valid bits; an unwritten entry reads as one
	logic [WEIGHT_W-1:0]   tap_mem [OVERSAMPLE];
	logic [OVERSAMPLE-1:0] tap_vld_q;
	logic [WEIGHT_W-1:0]   tap_rd_q;
	logic                  tap_rd_vld_q;

	imu_state_t state_q, state_d;
	logic [AW-1:0]                frame_cnt_q;
	logic [CH_W-1:0]              idx_q;
	logic [IN_SAMPLES_W-1:0]      samp_q;
	logic signed [SUM_W-1:0]      sums_q [NUM_CH];
	logic signed [PROD_W-1:0]     prod_q;
	logic [RES_W-1:0]             res_q [NUM_CH];
	logic                         m_tvalid_q;
	logic [OUT_DATA_W-1:0]        m_tdata_q;

	logic in_acc, tap_we, idx_ok, out_free, last_ch, last_frame;
	logic [CH_W-1:0]            sel_ch;
	logic signed [SUM_W-1:0]    sel_sum;
	logic [SCALE_W-1:0]         sel_scale;
	logic [SAMPLE_W-1:0]        cur_samp;
	logic signed [OFFSET_W-1:0] cur_off;
	logic signed [OFFSET_W:0]   adj;
	logic signed [WEIGHT_W-1:0] weight;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0]  mul_p;
	logic [PROD_W-1:0]          mag;
	logic                       neg;
	logic [RES_W-1:0]           sat;
	logic [WSUM_W-1:0]          divisor;
	div_req_t                   div_req;
	logic                       div_busy, div_done;
	logic [PROD_W-1:0]          div_quo;

	assign in_acc   = s_tvalid && s_tready;
	assign idx_ok   = {1'b0, s_tdata[IN_TAP_IDX_LO +: TAP_IDX_W]} < (TAP_IDX_W + 1)'(OVERSAMPLE);
	assign tap_we   = in_acc && (s_tuser == CMD_TAP_WRITE) && idx_ok;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_ch  = idx_q == CH_W'(NUM_CH - 1);
	assign last_frame = frame_cnt_q == AW'(OVERSAMPLE - 1);

	// configuration port: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_off_q   <= ACCEL_OFFSET_RST;
			gyro_off_q    <= GYRO_OFFSET_RST;
			wsum_q        <= WEIGHT_SUM_RST;
			accel_scale_q <= ACCEL_SCALE_RST;
			gyro_scale_q  <= GYRO_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACCEL_OFFSET: accel_off_q   <= cfg_data[OFFSET_W-1:0];
				CFG_GYRO_OFFSET:  gyro_off_q    <= cfg_data[OFFSET_W-1:0];
				CFG_WEIGHT_SUM:   wsum_q        <= cfg_data[WSUM_W-1:0];
				CFG_ACCEL_SCALE:  accel_scale_q <= cfg_data[SCALE_W-1:0];
				CFG_GYRO_SCALE:   gyro_scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// tap memory: one write port, one registered read port at the frame position
	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[s_tdata[IN_TAP_IDX_LO +: AW]] <= s_tdata[IN_WEIGHT_LO +: WEIGHT_W];
		end
		tap_rd_q <= tap_mem[frame_cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_q    <= '0;
			tap_rd_vld_q <= 1'b0;
		end else begin
			if (tap_we) begin
				tap_vld_q[s_tdata[IN_TAP_IDX_LO +: AW]] <= 1'b1;
			end
			tap_rd_vld_q <= tap_vld_q[frame_cnt_q];
		end
	end

	assign weight = tap_rd_vld_q ? tap_rd_q : WEIGHT_W'(1);

	// shared multiplier operand selection
	assign sel_ch    = (state_q == ST_MAC) ? idx_q : out_chan(idx_q);
	assign sel_sum   = sums_q[sel_ch];
	assign sel_scale = sel_ch[0] ? gyro_scale_q : accel_scale_q;
	assign cur_samp  = samp_q[idx_q * SAMPLE_W +: SAMPLE_W];
	assign cur_off   = idx_q[0] ? gyro_off_q : accel_off_q;
	assign adj       = $signed({2'b00, cur_samp}) + $signed({cur_off[OFFSET_W-1], cur_off});

	always_comb begin
		case (state_q)
			ST_MAC: begin
				mul_a = MUL_A_W'(adj);
				mul_b = MUL_B_W'(weight);
			end
			ST_FIN_LO: begin
				mul_a = $signed({1'b0, sel_sum[HALF_W-1:0]});
				mul_b = $signed({1'b0, sel_scale});
			end
			ST_FIN_HI: begin
				// upper half carries the sign of the sum
				mul_a = $signed({sel_sum[SUM_W-1], sel_sum[SUM_W-1:HALF_W]});
				mul_b = $signed({1'b0, sel_scale});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// divider request: magnitude of the scaled sum
	assign neg     = prod_q[PROD_W-1];
	assign mag     = neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign divisor = (wsum_q == '0) ? WSUM_W'(1) : wsum_q;

	assign div_req.start    = state_q == ST_DIV_GO;
	assign div_req.dividend = mag;
	assign div_req.divisor  = divisor;

	imu_dec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// apply sign and saturate to 32 bits
	always_comb begin
		if (neg) begin
			if (div_quo > PROD_W'(64'h8000_0000)) begin
				sat = 32'h8000_0000;
			end else begin
				sat = RES_W'(-div_quo[RES_W-1:0]);
			end
		end else begin
			if (div_quo > PROD_W'(64'h7FFF_FFFF)) begin
				sat = 32'h7FFF_FFFF;
			end else begin
				sat = div_quo[RES_W-1:0];
			end
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc && s_tuser == CMD_FRAME) begin
					state_d = ST_RD;
				end
			end
			ST_RD:   state_d = ST_MAC;
			ST_MAC: begin
				if (last_ch) begin
					state_d = last_frame ? ST_FIN_LO : ST_IDLE;
				end
			end
			ST_FIN_LO:   state_d = ST_FIN_HI;
			ST_FIN_HI:   state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = last_ch ? ST_OUT : ST_FIN_LO;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer counters, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_MAC: begin
					// accumulate one channel per cycle
					sums_q[idx_q] <= sums_q[idx_q] + SUM_W'(mul_p);
					if (last_ch) begin
						idx_q <= '0;
						if (!last_frame) begin
							frame_cnt_q <= frame_cnt_q + 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done && !last_ch) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						// hand the result over and open a new window
						frame_cnt_q <= '0;
						idx_q       <= '0;
						for (int i = 0; i < NUM_CH; i++) begin
							sums_q[i] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= s_tdata[IN_SAMPLES_W-1:0];
		end
		case (state_q)
			ST_FIN_LO: prod_q <= PROD_W'(mul_p);
			ST_FIN_HI: prod_q <= prod_q + $signed({mul_p[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}});
			default: ;
		endcase
		if (state_q == ST_DIV_WAIT && div_done) begin
			res_q[idx_q] <= sat;
		end
		if (state_q == ST_OUT && out_free) begin
			for (int i = 0; i < NUM_CH; i++) begin
				m_tdata_q[i*RES_W +: RES_W] <= res_q[i];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_ALWAYS(a_div_only_when_waiting, clk, arst_n, !div_busy || state_q == ST_DIV_WAIT)
	`ASSERT_ALWAYS(a_frame_cnt_in_window, clk, arst_n, frame_cnt_q <= AW'(OVERSAMPLE - 1))
	`ASSERT_ALWAYS(a_idx_in_range, clk, arst_n, idx_q < CH_W'(NUM_CH))
	`ASSERT_NEXT(a_window_cleared, clk, arst_n, state_q == ST_OUT && out_free,
		m_tvalid_q && frame_cnt_q == '0 && sums_q[0] == '0 && sums_q[5] == '0)

endmodule

// File: tb/sv/oversampled_imu_decimator_tb.sv
module oversampled_imu_decimator_tb;
	import imu_dec_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the tap table, the six running sums and the window position, and
	// holds the decimated outputs that the block still owes us.
	class decimated_window_tracker;
		logic signed [WEIGHT_W-1:0] taps [OVERSAMPLE_DEF];
		longint                     sums [NUM_CH];
		int                         frame_pos;
		logic signed [OFFSET_W-1:0] accel_off;
		logic signed [OFFSET_W-1:0] gyro_off;
		logic [WSUM_W-1:0]          wsum;
		logic [SCALE_W-1:0]         accel_k;
		logic [SCALE_W-1:0]         gyro_k;
		logic [OUT_DATA_W-1:0]      owed_windows [$];
		int                         errors;
		int                         frames;
		int                         tap_writes;
		int                         taps_dropped;
		int                         windows_checked;

		function new();
			for (int i = 0; i < OVERSAMPLE_DEF; i++)
				taps[i] = 1;
			for (int i = 0; i < NUM_CH; i++)
				sums[i] = 0;
			frame_pos = 0;
			accel_off = ACCEL_OFFSET_RST;
			gyro_off = GYRO_OFFSET_RST;
			wsum = WEIGHT_SUM_RST;
			accel_k = ACCEL_SCALE_RST;
			gyro_k = GYRO_SCALE_RST;
			errors = 0;
			frames = 0;
			tap_writes = 0;
			taps_dropped = 0;
			windows_checked = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_ACCEL_OFFSET: accel_off = val[OFFSET_W-1:0];
				CFG_GYRO_OFFSET:  gyro_off = val[OFFSET_W-1:0];
				CFG_WEIGHT_SUM:   wsum = val[WSUM_W-1:0];
				CFG_ACCEL_SCALE:  accel_k = val[SCALE_W-1:0];
				CFG_GYRO_SCALE:   gyro_k = val[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		// Scale, divide toward zero (a zero divisor counts as one), clamp to 32 bits.
		function logic [RES_W-1:0] scale_and_divide(longint acc, logic [SCALE_W-1:0] k);
			longint prod;
			longint divisor;
			longint q;
			prod = acc * longint'(k);
			divisor = (wsum == 0) ? 64'sd1 : longint'(wsum);
			q = prod / divisor;
			if (q > 64'sd2147483647)
				q = 64'sd2147483647;
			if (q < -64'sd2147483648)
				q = -64'sd2147483648;
			return q[RES_W-1:0];
		endfunction

		function void note_item(logic cmd, logic [IN_DATA_W-1:0] d);
			logic [TAP_IDX_W-1:0]       idx;
			logic signed [WEIGHT_W-1:0] w;
			longint                     smp;
			longint                     off;
			logic [OUT_DATA_W-1:0]      res;
			if (cmd == CMD_TAP_WRITE) begin
				idx = d[IN_TAP_IDX_LO +: TAP_IDX_W];
				tap_writes++;
				// indexes past the window length are dropped
				if (idx < OVERSAMPLE_DEF)
					taps[idx] = d[IN_WEIGHT_LO +: WEIGHT_W];
				else
					taps_dropped++;
				return;
			end
			frames++;
			w = taps[frame_pos];
			for (int ch = 0; ch < NUM_CH; ch++) begin
				smp = longint'(d[ch*SAMPLE_W +: SAMPLE_W]);
				off = (ch % 2 == 1) ? longint'(gyro_off) : longint'(accel_off);
				sums[ch] += (smp + off) * longint'(w);
			end
			frame_pos++;
			if (frame_pos < OVERSAMPLE_DEF)
				return;
			// output order: accel X, Y, Z then gyro X, Y, Z
			res[0*RES_W +: RES_W] = scale_and_divide(sums[0], accel_k);
			res[1*RES_W +: RES_W] = scale_and_divide(sums[2], accel_k);
			res[2*RES_W +: RES_W] = scale_and_divide(sums[4], accel_k);
			res[3*RES_W +: RES_W] = scale_and_divide(sums[1], gyro_k);
			res[4*RES_W +: RES_W] = scale_and_divide(sums[3], gyro_k);
			res[5*RES_W +: RES_W] = scale_and_divide(sums[5], gyro_k);
			owed_windows.push_back(res);
			for (int ch = 0; ch < NUM_CH; ch++)
				sums[ch] = 0;
			frame_pos = 0;
		endfunction

		function string field_name(int i);
			case (i)
				0: return "accel_x";
				1: return "accel_y";
				2: return "accel_z";
				3: return "rate_x";
				4: return "rate_y";
				default: return "rate_z";
			endcase
		endfunction

		function void check_window(logic [OUT_DATA_W-1:0] got);
			logic [OUT_DATA_W-1:0] want;
			logic [RES_W-1:0]      e;
			logic [RES_W-1:0]      a;
			if (owed_windows.size() == 0) begin
				$display("%0t: unexpected output transaction, actual %h", $time, got);
				errors++;
				return;
			end
			want = owed_windows.pop_front();
			windows_checked++;
			for (int i = 0; i < NUM_CH; i++) begin
				e = want[i*RES_W +: RES_W];
				a = got[i*RES_W +: RES_W];
				if (e !== a) begin
					$display("%0t: %s expected %0d actual %0d", $time, field_name(i),
						$signed(e), $signed(a));
					errors++;
				end
			end
		endfunction

		function int owed();
			return owed_windows.size();
		endfunction
	endclass

	localparam int STALL_LIMIT  = 20000;
	localparam int LONG_HOLD    = 3000;
	localparam int SETTLE_CYC   = 30;
	localparam int PHASE_ITEMS  = 150;
	localparam int RAND_PHASES  = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// sample_ch0..5 [71:0], tap_index [77:72], tap_weight [93:78]
	logic [IN_DATA_W-1:0]  s_tdata;
	// command [0]
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, 32 bits each from bit 0
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	decimated_window_tracker tracker = new();

	int burst_left;
	int cfg_settings;
	int quiet_cycles;

	oversampled_imu_decimator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every output transaction against the oldest owed window.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_window(m_tdata);
	end

	// Watchdog: end the run when no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Output side: cycle through ready patterns, and once hold ready low for a
	// long stretch so the block backs up and stalls its input.
	initial begin : output_stall
		int  cyc;
		bit  long_hold_done;
		cyc = 0;
		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!long_hold_done && tracker.windows_checked >= 5) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			case ((cyc / 160) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((cyc % 7) < 4);
			endcase
			cyc++;
			@(posedge clk);
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_item(logic [NUM_CH*SAMPLE_W-1:0] samples,
			logic [TAP_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] w);
		return {{(IN_DATA_W - IN_WEIGHT_LO - WEIGHT_W){1'b0}}, w, idx, samples};
	endfunction

	// Offer one input transaction and hold it until taken. Bursts of random
	// length are separated by random gaps with valid low.
	task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		tracker.note_item(cmd, data);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_tap(input int idx, input int w);
		send_item(CMD_TAP_WRITE, pack_item(
			(NUM_CH*SAMPLE_W)'({$urandom(), $urandom(), $urandom()}),
			TAP_IDX_W'(idx), WEIGHT_W'(w)));
	endtask

	task automatic send_frame(input logic [NUM_CH*SAMPLE_W-1:0] samples);
		send_item(CMD_FRAME, pack_item(samples, TAP_IDX_W'($urandom()),
			WEIGHT_W'($urandom())));
	endtask

	// Hold the input until every owed window is out, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.owed() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write all five registers back to back; lower valid only after the last.
	task automatic apply_config(input int a_off, input int g_off, input int ws,
			input int a_k, input int g_k);
		cfg_reg_t                idx [5];
		logic [CFG_DATA_W-1:0]   val [5];
		idx = '{CFG_ACCEL_OFFSET, CFG_GYRO_OFFSET, CFG_WEIGHT_SUM,
			CFG_ACCEL_SCALE, CFG_GYRO_SCALE};
		val = '{CFG_DATA_W'(a_off), CFG_DATA_W'(g_off), CFG_DATA_W'(ws),
			CFG_DATA_W'(a_k), CFG_DATA_W'(g_k)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		cfg_settings++;
	endtask

	function automatic logic [NUM_CH*SAMPLE_W-1:0] random_samples();
		logic [NUM_CH*SAMPLE_W-1:0] s;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case ($urandom_range(0, 7))
				0: s[ch*SAMPLE_W +: SAMPLE_W] = '0;
				1: s[ch*SAMPLE_W +: SAMPLE_W] = '1;
				default: s[ch*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom());
			endcase
		end
		return s;
	endfunction

	task automatic send_random_item();
		int idx;
		int w;
		if ($urandom_range(0, 9) < 2) begin
			// mostly valid tap positions, some past the window end
			idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, OVERSAMPLE_DEF - 1);
			w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) - 4 : $urandom();
			send_tap(idx, w);
		end else begin
			send_frame(random_samples());
		end
	endtask

	initial begin : stimulus
		int a_off;
		int g_off;
		int ws;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_FRAME;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ACCEL_OFFSET;
		cfg_data <= '0;
		burst_left = 0;
		cfg_settings = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: weight extremes, dropped tap indexes,
		// sample extremes on every channel.
		send_tap(0, 32767);
		send_tap(OVERSAMPLE_DEF - 1, -32768);
		send_tap(OVERSAMPLE_DEF, 16'h1234);
		send_tap(63, 16'hFFFF);
		send_frame({NUM_CH{12'hFFF}});
		send_frame({NUM_CH{12'h000}});
		send_frame({3{12'hFFF, 12'h000}});
		send_frame({3{12'h000, 12'hFFF}});
		for (int i = 0; i < OVERSAMPLE_DEF - 4; i++)
			send_frame(random_samples());
		drain();

		// Directed: accel driven to negative saturation, gyro to positive.
		apply_config(-4095, 0, 1, 65535, 65535);
		send_tap(OVERSAMPLE_DEF - 1, 32767);
		for (int i = 0; i < OVERSAMPLE_DEF; i++)
			send_frame({3{12'hFFF, 12'h000}});
		drain();

		// Random phases, each under its own register setting and each closed on
		// a window boundary so the next write finds the block idle.
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: apply_config(0, -4095, 32767, 0, 65535);
				1: apply_config(-$urandom_range(0, 4095), -$urandom_range(0, 4095), 0,
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				default: begin
					a_off = -$urandom_range(0, 4095);
					g_off = -$urandom_range(0, 4095);
					ws = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 32767);
					apply_config(a_off, g_off, ws, $urandom_range(0, 65535),
						$urandom_range(0, 65535));
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_item();
			while (tracker.frame_pos != 0)
				send_frame(random_samples());
			drain();
		end

		$display("covered %0d frames, %0d tap writes (%0d past the window end), %0d windows",
			tracker.frames, tracker.tap_writes, tracker.taps_dropped, tracker.windows_checked);
		$display("under %0d register settings including saturation and zero divisor",
			cfg_settings + 1);
		if (tracker.errors == 0 && tracker.owed() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/imu_dec_pkg.sv
design/imu_dec_div.sv
design/oversampled_imu_decimator.sv
tb/sv/oversampled_imu_decimator_tb.sv
